@@ hw/rtl/rse_pkg.sv @@
// Shared types, codes and helpers for the RPN stack evaluator.
package rse_pkg;

	typedef enum logic [1:0] {
		ACT_PUSH    = 2'd0,
		ACT_OPER    = 2'd1,
		ACT_UNKNOWN = 2'd2,
		ACT_EOL     = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_MALFORMED = 2'd1,
		ST_FAULT     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		RD_TOP  = 2'd0,
		RD_NEXT = 2'd1,
		RD_BASE = 2'd2
	} rd_sel_t;

	typedef enum logic [1:0] {
		RES_ADDSUB = 2'd0,
		RES_MUL    = 2'd1,
		RES_DIV    = 2'd2
	} res_sel_t;

	typedef struct packed {
		action_t            action;
		logic signed [31:0] number;
		opcode_t            operator_code;
	} token_t;

	typedef struct packed {
		logic signed [31:0] value;
		status_t            status;
	} result_t;

	typedef struct packed {
		logic     load_token;
		logic     push;
		logic     abandon;
		logic     set_fault;
		logic     rd_en;
		rd_sel_t  rd_sel;
		logic     cap_right;
		logic     mul_load;
		logic     div_load;
		logic     div_step;
		logic     wr_result;
		res_sel_t res_sel;
		logic     emit;
	} dp_cmd_t;

	typedef struct packed {
		action_t action;
		opcode_t op;
		logic    empty;
		logic    single;
		logic    full;
		logic    abandoned;
		logic    right_zero;
		logic    div_done;
	} dp_status_t;

	// restoring divider: 32 integer + 16 fraction bits of quotient
	localparam int unsigned DIV_STEPS = 48;
	localparam int unsigned DIV_CNT_W = 6;

	localparam logic signed [47:0] SAT_MAX48 = 48'sd2147483647;
	localparam logic signed [47:0] SAT_MIN48 = -48'sd2147483648;
	localparam logic signed [31:0] Q_MAX     = 32'sh7FFFFFFF;
	localparam logic signed [31:0] Q_MIN     = 32'sh80000000;

	function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
		logic signed [31:0] r;
		if (v > SAT_MAX48)
			r = Q_MAX;
		else if (v < SAT_MIN48)
			r = Q_MIN;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

@@ hw/rtl/rpn_stack_evaluator.sv @@
// Top level: RPN expression evaluator, Q16.16 values on a STACK_DEPTH-entry stack.
// Busy rises at the accepting edge and stays high while a token is processed; div runs a
// 48-step restoring divider. Busy low means a new transaction is taken at the next edge.
// The result strobe rises at the same edge that drops busy at end of line and is never
// stalled. Reset clears the stack count and the abandon and fault flags; stack memory keeps
// its contents and needs no clearing pass.
module rpn_stack_evaluator #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  rse_pkg::token_t  token,
	output logic             done,
	output rse_pkg::result_t result
);
	import rse_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t sts;

	rse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	rse_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.token  (token),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule

@@ hw/rtl/rse_ctrl.sv @@
// Sequencing state machine for the RPN stack evaluator.
module rse_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  rse_pkg::dp_status_t sts,
	output rse_pkg::dp_cmd_t    cmd,
	output logic                busy
);
	import rse_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_DECODE    = 8'b0000_0010,
		S_READ_NEXT = 8'b0000_0100,
		S_OPERATE   = 8'b0000_1000,
		S_MUL_WB    = 8'b0001_0000,
		S_DIV       = 8'b0010_0000,
		S_DIV_WB    = 8'b0100_0000,
		S_EMIT      = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load_token = 1'b1;
					state_d        = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_IDLE;
				if (sts.action == ACT_EOL) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_BASE;
					state_d    = S_EMIT;
				end else if (!sts.abandoned) begin
					unique case (sts.action)
						ACT_PUSH: begin
							if (sts.full) begin
								cmd.abandon   = 1'b1;
								cmd.set_fault = 1'b1;
							end else begin
								cmd.push = 1'b1;
							end
						end
						ACT_OPER: begin
							if (sts.single) begin
								cmd.abandon = 1'b1;
							end else if (!sts.empty) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = RD_TOP;
								state_d    = S_READ_NEXT;
							end
						end
						default: cmd.abandon = 1'b1;
					endcase
				end
			end
			S_READ_NEXT: begin
				cmd.cap_right = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_sel    = RD_NEXT;
				state_d       = S_OPERATE;
			end
			S_OPERATE: begin
				unique case (sts.op)
					OP_MUL: begin
						cmd.mul_load = 1'b1;
						state_d      = S_MUL_WB;
					end
					OP_DIV: begin
						if (sts.right_zero) begin
							cmd.abandon   = 1'b1;
							cmd.set_fault = 1'b1;
							state_d       = S_IDLE;
						end else begin
							cmd.div_load = 1'b1;
							state_d      = S_DIV;
						end
					end
					default: begin
						cmd.wr_result = 1'b1;
						cmd.res_sel   = RES_ADDSUB;
						state_d       = S_IDLE;
					end
				endcase
			end
			S_MUL_WB: begin
				cmd.wr_result = 1'b1;
				cmd.res_sel   = RES_MUL;
				state_d       = S_IDLE;
			end
			S_DIV: begin
				if (sts.div_done)
					state_d = S_DIV_WB;
				else
					cmd.div_step = 1'b1;
			end
			S_DIV_WB: begin
				cmd.wr_result = 1'b1;
				cmd.res_sel   = RES_DIV;
				state_d       = S_IDLE;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				state_d  = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ hw/rtl/rse_datapath.sv @@
// Stack memory, arithmetic units and result register of the RPN stack evaluator.
module rse_datapath #(
	parameter int unsigned STACK_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  rse_pkg::token_t     token,
	input  rse_pkg::dp_cmd_t    cmd,
	output rse_pkg::dp_status_t sts,
	output logic                done,
	output rse_pkg::result_t    result
);
	import rse_pkg::*;

	localparam int unsigned AddrW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);

	logic signed [31:0] mem [STACK_DEPTH];

	token_t             token_q;
	logic [CntW-1:0]    count_q;
	logic               abandoned_q;
	logic               fault_q;
	logic signed [31:0] rd_q;
	logic signed [31:0] right_q;
	logic signed [63:0] product_q;

	logic [31:0]           dvs_q;
	logic [31:0]           rem_q;
	logic [47:0]           quo_q;
	logic                  neg_q;
	logic [DIV_CNT_W-1:0]  div_cnt_q;

	logic                  done_q;
	result_t               result_q;

	logic [CntW-1:0]    cnt_m1, cnt_m2;
	logic [AddrW-1:0]   rd_addr, wr_addr;
	logic               wr_en;
	logic signed [31:0] wr_data;
	logic signed [31:0] res_addsub, res_mul, res_div;
	logic signed [47:0] sum48;
	logic [32:0]        trial;
	logic [33:0]        diff;
	logic [31:0]        abs_left, abs_right;

	assign cnt_m1 = count_q - CntW'(1);
	assign cnt_m2 = count_q - CntW'(2);

	always_comb begin
		case (cmd.rd_sel)
			RD_TOP:  rd_addr = cnt_m1[AddrW-1:0];
			RD_NEXT: rd_addr = cnt_m2[AddrW-1:0];
			default: rd_addr = '0;
		endcase
	end

	// add / subtract, saturated
	always_comb begin
		if (token_q.operator_code == OP_SUB)
			sum48 = {{16{rd_q[31]}}, rd_q} - {{16{right_q[31]}}, right_q};
		else
			sum48 = {{16{rd_q[31]}}, rd_q} + {{16{right_q[31]}}, right_q};
		res_addsub = sat32(sum48);
	end

	// product >> 16 is floor division by 65536
	assign res_mul = sat32(product_q[63:16]);

	always_comb begin
		if (neg_q) begin
			if ((|quo_q[47:32]) || (quo_q[31] && (|quo_q[30:0])))
				res_div = Q_MIN;
			else
				res_div = 32'sd0 - $signed(quo_q[31:0]);
		end else begin
			if (|quo_q[47:31])
				res_div = Q_MAX;
			else
				res_div = $signed({1'b0, quo_q[30:0]});
		end
	end

	always_comb begin
		case (cmd.res_sel)
			RES_MUL: wr_data = res_mul;
			RES_DIV: wr_data = res_div;
			default: wr_data = res_addsub;
		endcase
		if (cmd.push) begin
			wr_data = token_q.number;
			wr_addr = count_q[AddrW-1:0];
		end else begin
			wr_addr = cnt_m2[AddrW-1:0];
		end
		wr_en = cmd.push | cmd.wr_result;
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (cmd.rd_en)
			rd_q <= mem[rd_addr];
	end

	// divider operands
	assign abs_left  = rd_q[31] ? (32'd0 - rd_q) : rd_q;
	assign abs_right = right_q[31] ? (32'd0 - right_q) : right_q;
	assign trial     = {rem_q, quo_q[47]};
	assign diff      = {1'b0, trial} - {2'b00, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.load_token)
			token_q <= token;
		if (cmd.cap_right)
			right_q <= rd_q;
		if (cmd.mul_load)
			product_q <= 64'(rd_q) * 64'(right_q);
		if (cmd.div_load) begin
			dvs_q <= abs_right;
			rem_q <= '0;
			quo_q <= {abs_left, 16'd0};
			neg_q <= rd_q[31] ^ right_q[31];
		end else if (cmd.div_step) begin
			rem_q <= diff[33] ? trial[31:0] : diff[31:0];
			quo_q <= {quo_q[46:0], ~diff[33]};
		end
		if (cmd.emit) begin
			if (fault_q) begin
				result_q.value  <= '0;
				result_q.status <= ST_FAULT;
			end else if (count_q != CntW'(1)) begin
				result_q.value  <= '0;
				result_q.status <= ST_MALFORMED;
			end else begin
				result_q.value  <= rd_q;
				result_q.status <= ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			abandoned_q <= 1'b0;
			fault_q     <= 1'b0;
			div_cnt_q   <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= cmd.emit;
			if (cmd.div_load)
				div_cnt_q <= '0;
			else if (cmd.div_step)
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			if (cmd.emit) begin
				count_q     <= '0;
				abandoned_q <= 1'b0;
				fault_q     <= 1'b0;
			end else begin
				if (cmd.set_fault)
					fault_q <= 1'b1;
				if (cmd.abandon) begin
					count_q     <= '0;
					abandoned_q <= 1'b1;
				end else if (cmd.push) begin
					count_q <= count_q + CntW'(1);
				end else if (cmd.wr_result) begin
					count_q <= cnt_m1;
				end
			end
		end
	end

	assign sts.action     = token_q.action;
	assign sts.op         = token_q.operator_code;
	assign sts.empty      = (count_q == '0);
	assign sts.single     = (count_q == CntW'(1));
	assign sts.full       = (count_q == CntW'(STACK_DEPTH));
	assign sts.abandoned  = abandoned_q;
	assign sts.right_zero = (right_q == '0);
	assign sts.div_done   = (div_cnt_q == DIV_CNT_W'(DIV_STEPS));

	assign done   = done_q;
	assign result = result_q;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the RPN stack evaluator: directed script, then random lines.
`timescale 1ns / 100ps

module tb_top;
	import rse_pkg::*;

	localparam int DEPTH      = 16;
	localparam int RAND_ITEMS = 700;
	localparam int LIMIT      = 600000;
	localparam int NSTEPS     = 26;

	typedef struct packed {
		action_t     act;
		logic [31:0] num;
		opcode_t     op;
		logic [4:0]  reps;
		logic        pinned;
		logic [31:0] val;
		status_t     st;
	} script_row_t;

	// pinned rows carry the result expected at end of line
	localparam script_row_t SCRIPT [NSTEPS] = '{
		'{ACT_EOL,     32'h0000_0000, OP_ADD, 5'd1, 1'b1, 32'h0000_0000, ST_MALFORMED},
		'{ACT_PUSH,    32'h7FFF_FFFF, OP_MUL, 5'd2, 1'b0, 32'h0,         ST_OK},
		'{ACT_OPER,    32'hFFFF_FFFF, OP_ADD, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_PUSH,    32'h8000_0000, OP_DIV, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_PUSH,    32'h0000_0001, OP_SUB, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_OPER,    32'h0000_0000, OP_SUB, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_PUSH,    32'hFFFF_FFFF, OP_ADD, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_OPER,    32'h5555_5555, OP_DIV, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_OPER,    32'hAAAA_AAAA, OP_MUL, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_EOL,     32'hFFFF_FFFF, OP_DIV, 5'd1, 1'b1, 32'h7FFF_FFFF, ST_OK},
		'{ACT_OPER,    32'h0000_0000, OP_ADD, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_PUSH,    32'hFFFF_0000, OP_ADD, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_PUSH,    32'h0002_0000, OP_ADD, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_OPER,    32'h0000_0000, OP_DIV, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_EOL,     32'h0000_0000, OP_ADD, 5'd1, 1'b1, 32'hFFFF_8000, ST_OK},
		'{ACT_PUSH,    32'h0003_0000, OP_ADD, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_PUSH,    32'h0000_0000, OP_ADD, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_OPER,    32'h0000_0000, OP_DIV, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_EOL,     32'h0000_0000, OP_ADD, 5'd1, 1'b1, 32'h0000_0000, ST_FAULT},
		'{ACT_PUSH,    32'h0005_0000, OP_ADD, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_OPER,    32'h0000_0000, OP_SUB, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_EOL,     32'h0000_0000, OP_ADD, 5'd1, 1'b1, 32'h0000_0000, ST_MALFORMED},
		'{ACT_UNKNOWN, 32'h0000_0000, OP_ADD, 5'd1, 1'b0, 32'h0,         ST_OK},
		'{ACT_EOL,     32'h0000_0000, OP_ADD, 5'd1, 1'b1, 32'h0000_0000, ST_MALFORMED},
		'{ACT_PUSH,    32'h0001_0000, OP_ADD, 5'd2, 1'b0, 32'h0,         ST_OK},
		'{ACT_EOL,     32'h0000_0000, OP_ADD, 5'd1, 1'b1, 32'h0000_0000, ST_MALFORMED}
	};

	logic    clk;
	logic    arst_n;
	logic    start;
	logic    busy;
	token_t  token;
	logic    done;
	result_t result;

	result_t            pending_results[$];
	logic signed [31:0] stk_vals [DEPTH];
	int                 stk_cnt;
	bit                 line_dropped;
	bit                 fault_flag;
	int                 live_items;
	int                 gap_pct;
	int                 errors;
	int                 cycles;
	int                 n_ok, n_malformed, n_fault;

	rpn_stack_evaluator #(.STACK_DEPTH(DEPTH)) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.token  (token),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic signed [31:0] clamp_q(input longint v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647)
			r = 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648)
			r = 32'sh8000_0000;
		else
			r = v[31:0];
		return r;
	endfunction

	function automatic void drop_line();
		stk_cnt = 0;
		line_dropped = 1'b1;
	endfunction

	// next-state and result for one accepted token
	function automatic void evaluate(input token_t t, output bit emits, output result_t r);
		logic signed [31:0] lhs, rhs;
		longint             acc;
		emits = 1'b0;
		r = '0;
		acc = 0;
		if (t.action == ACT_EOL) begin
			live_items++;
			emits = 1'b1;
			if (fault_flag)
				r.status = ST_FAULT;
			else if (stk_cnt != 1)
				r.status = ST_MALFORMED;
			else begin
				r.status = ST_OK;
				r.value = stk_vals[0];
			end
			stk_cnt = 0;
			line_dropped = 1'b0;
			fault_flag = 1'b0;
		end else if (!line_dropped) begin
			live_items++;
			if (t.action == ACT_PUSH) begin
				if (stk_cnt >= DEPTH) begin
					fault_flag = 1'b1;
					drop_line();
				end else begin
					stk_vals[stk_cnt] = t.number;
					stk_cnt++;
				end
			end else if (t.action == ACT_OPER) begin
				if (stk_cnt == 1)
					drop_line();
				else if (stk_cnt > 1) begin
					rhs = stk_vals[stk_cnt-1];
					lhs = stk_vals[stk_cnt-2];
					case (t.operator_code)
						OP_ADD: acc = longint'(lhs) + longint'(rhs);
						OP_SUB: acc = longint'(lhs) - longint'(rhs);
						OP_MUL: acc = (longint'(lhs) * longint'(rhs)) >>> 16;
						default: if (rhs != 0) acc = (longint'(lhs) * 65536) / longint'(rhs);
					endcase
					if (t.operator_code == OP_DIV && rhs == 0) begin
						fault_flag = 1'b1;
						drop_line();
					end else begin
						stk_vals[stk_cnt-2] = clamp_q(acc);
						stk_cnt--;
					end
				end
			end else
				drop_line();
		end
	endfunction

	// present one transaction at the falling edge, return at the falling edge after acceptance
	task automatic issue(input token_t t, input bit pinned = 1'b0, input result_t pin = '0);
		bit      emits;
		result_t r;
		if ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		start <= 1'b1;
		token <= t;
		do @(posedge clk); while (busy);
		evaluate(t, emits, r);
		if (emits)
			pending_results.push_back(pinned ? pin : r);
		@(negedge clk);
	endtask

	function automatic token_t mk(input action_t a, input logic [31:0] n, input opcode_t o);
		token_t t;
		t.action = a;
		t.number = n;
		t.operator_code = o;
		return t;
	endfunction

	function automatic logic [31:0] rand_q();
		logic [31:0] v;
		case ($urandom_range(9))
			0: case ($urandom_range(4))
				0: v = 32'h7FFF_FFFF;
				1: v = 32'h8000_0000;
				2: v = 32'h0000_0000;
				3: v = 32'hFFFF_FFFF;
				default: v = 32'h0001_0000;
			endcase
			1, 2: v = $urandom;
			default: v = $signed($urandom) >>> 12;
		endcase
		return v;
	endfunction

	task automatic push_rand();
		issue(mk(ACT_PUSH, rand_q(), opcode_t'($urandom_range(3))));
	endtask

	task automatic eol_rand();
		issue(mk(ACT_EOL, $urandom, opcode_t'($urandom_range(3))));
	endtask

	// well-formed expression that reduces to one value
	task automatic good_line();
		int goal, held, pushed;
		goal = $urandom_range(1, ($urandom_range(9) == 0) ? DEPTH : 5);
		held = 0;
		pushed = 0;
		while (pushed < goal || held > 1) begin
			if (pushed < goal && (held < 2 || (held < DEPTH && $urandom_range(1)))) begin
				push_rand();
				held++;
				pushed++;
			end else begin
				issue(mk(ACT_OPER, $urandom, opcode_t'($urandom_range(3))));
				held--;
			end
		end
		eol_rand();
	endtask

	task automatic noise_line();
		repeat ($urandom_range(1, 8))
			issue(mk(action_t'($urandom_range(3)), rand_q(), opcode_t'($urandom_range(3))));
		eol_rand();
	endtask

	task automatic overflow_line();
		repeat (DEPTH + $urandom_range(1, 2))
			push_rand();
		if ($urandom_range(1))
			issue(mk(ACT_OPER, $urandom, opcode_t'($urandom_range(3))));
		eol_rand();
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected result: expected none, actual value %h status %0d",
					$time, result.value, result.status);
			end else begin
				want = pending_results.pop_front();
				if (result.value !== want.value) begin
					errors++;
					$display("%0t: value mismatch: expected %h, actual %h",
						$time, want.value, result.value);
				end
				if (result.status !== want.status) begin
					errors++;
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, result.status);
				end
				case (want.status)
					ST_OK: n_ok++;
					ST_MALFORMED: n_malformed++;
					default: n_fault++;
				endcase
			end
		end
	end

	initial begin
		token_t tok;
		result_t pin;
		int base, ph, pick;
		arst_n = 1'b0;
		start = 1'b0;
		token = '0;
		stk_cnt = 0;
		line_dropped = 1'b0;
		fault_flag = 1'b0;
		live_items = 0;
		errors = 0;
		n_ok = 0;
		n_malformed = 0;
		n_fault = 0;
		gap_pct = 14;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < NSTEPS; i++) begin
			tok = mk(SCRIPT[i].act, SCRIPT[i].num, SCRIPT[i].op);
			pin.value = SCRIPT[i].val;
			pin.status = SCRIPT[i].st;
			for (int k = 0; k < SCRIPT[i].reps; k++)
				issue(tok, SCRIPT[i].pinned, pin);
		end

		base = live_items;
		for (ph = 0; ph < 3; ph++) begin
			gap_pct = (ph == 0) ? 14 : (ph == 1) ? 82 : 0;
			while (live_items < base + (ph + 1) * RAND_ITEMS / 3) begin
				pick = $urandom_range(99);
				if (pick < 80)
					good_line();
				else if (pick < 92)
					noise_line();
				else
					overflow_line();
			end
		end
		start <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("%0d tokens evaluated over directed and random lines, %0d cycles", live_items,
			cycles);
		$display("results checked: %0d ok, %0d malformed, %0d faulted; %0d errors", n_ok,
			n_malformed, n_fault, errors);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
